// ===== src/bmp565_pkg.sv =====
// Shared types and constants for the 24-bit BMP to RGB565 stream converter.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bmp565_pkg;

    // Result codes
    typedef enum logic [1:0] {
        KIND_WINDOW = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_END    = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_MAX_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_WINDOW_LEFT   = 2'd2;
    localparam logic [1:0] CFG_WINDOW_BOTTOM = 2'd3;

    // Configuration reset values
    localparam logic [15:0] RST_MAX_WIDTH     = 16'd320;
    localparam logic [15:0] RST_MAX_HEIGHT    = 16'd240;
    localparam logic [15:0] RST_WINDOW_LEFT   = 16'd0;
    localparam logic [15:0] RST_WINDOW_BOTTOM = 16'd239;

    // Header byte positions (little endian fields)
    localparam logic [5:0] HDR_WIDTH_LO  = 6'd18;
    localparam logic [5:0] HDR_WIDTH_HI  = 6'd19;
    localparam logic [5:0] HDR_HEIGHT_LO = 6'd22;
    localparam logic [5:0] HDR_HEIGHT_HI = 6'd23;
    localparam logic [5:0] HDR_BPP       = 6'd28;
    localparam logic [5:0] HDR_SIZE_B0   = 6'h22;
    localparam logic [5:0] HDR_SIZE_B1   = 6'h23;
    localparam logic [5:0] HDR_SIZE_B2   = 6'h24;
    localparam logic [5:0] HDR_SIZE_B3   = 6'h25;
    localparam logic [5:0] HDR_LAST      = 6'd53;

    // Only this pixel depth is accepted
    localparam logic [7:0] BPP_SUPPORTED = 8'd24;

    typedef struct packed {
        logic [15:0] max_width;
        logic [15:0] max_height;
        logic [15:0] window_left;
        logic [15:0] window_bottom;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] win_left;
        logic [15:0] win_top;
        logic [15:0] win_right;
        logic [15:0] win_low;
        logic [15:0] color;
        logic        image_done;
    } res_t;

endpackage

`default_nettype wire

// ===== src/bmp565_cfg.sv =====
// Configuration register file: limits and display window position.
// Depends on bmp565_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmp565_cfg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_addr,
    input  wire logic [15:0]       cfg_wdata,
    output bmp565_pkg::cfg_t       cfg
);
    import bmp565_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write index
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_MAX_WIDTH:     cfg_next.max_width     = cfg_wdata;
                CFG_MAX_HEIGHT:    cfg_next.max_height    = cfg_wdata;
                CFG_WINDOW_LEFT:   cfg_next.window_left   = cfg_wdata;
                CFG_WINDOW_BOTTOM: cfg_next.window_bottom = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_width     <= RST_MAX_WIDTH;
            cfg_reg.max_height    <= RST_MAX_HEIGHT;
            cfg_reg.window_left   <= RST_WINDOW_LEFT;
            cfg_reg.window_bottom <= RST_WINDOW_BOTTOM;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/bmp565_parse.sv =====
// Byte parser: header capture, size checks, BGR triple assembly, row padding.
// Computes at most one result per accepted item. Depends on bmp565_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmp565_parse (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire logic [7:0]        byte_value,
    input  wire logic              start_of_file,
    input  bmp565_pkg::cfg_t       cfg,
    output logic                   res_valid,
    output bmp565_pkg::res_t       res
);
    import bmp565_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HEAD = 4'b0010,
        PH_DATA = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [5:0]  header_pos_reg, header_pos_next;
    logic [15:0] img_width_reg, img_width_next;
    logic [15:0] img_height_reg, img_height_next;
    logic [7:0]  bit_depth_reg, bit_depth_next;
    logic [31:0] data_left_reg, data_left_next;
    logic [1:0]  pad_bytes_reg, pad_bytes_next;
    logic [1:0]  pad_left_reg, pad_left_next;
    logic [15:0] row_pixels_reg, row_pixels_next;
    logic [1:0]  triple_pos_reg, triple_pos_next;
    logic [7:0]  blue_byte_reg, blue_byte_next;
    logic [7:0]  green_byte_reg, green_byte_next;

    // State as seen by this item, after an optional start mark
    phase_t      ph_e;
    logic [5:0]  pos_e;
    logic [15:0] width_e, height_e, row_e;
    logic [7:0]  depth_e;
    logic [31:0] left_e, left_dec;
    logic [1:0]  padb_e, padl_e, padl_dec, tri_e;
    logic        few_left, few_after, reject;
    logic [15:0] row_inc;

    always_comb
    begin
        ph_e     = start_of_file ? PH_HEAD : phase_reg;
        pos_e    = start_of_file ? 6'd0  : header_pos_reg;
        width_e  = start_of_file ? 16'd0 : img_width_reg;
        height_e = start_of_file ? 16'd0 : img_height_reg;
        depth_e  = start_of_file ? 8'd0  : bit_depth_reg;
        left_e   = start_of_file ? 32'd0 : data_left_reg;
        padb_e   = start_of_file ? 2'd0  : pad_bytes_reg;
        padl_e   = start_of_file ? 2'd0  : pad_left_reg;
        row_e    = start_of_file ? 16'd0 : row_pixels_reg;
        tri_e    = start_of_file ? 2'd0  : triple_pos_reg;
    end

    // Saturating byte count and the common end test
    assign left_dec  = (left_e != 32'd0) ? left_e - 32'd1 : 32'd0;
    assign few_left  = (left_e[31:2] == 30'd0) && (left_e[1:0] != 2'd3);
    assign few_after = (left_dec[31:2] == 30'd0) && (left_dec[1:0] != 2'd3);
    assign padl_dec  = padl_e - 2'd1;
    assign row_inc   = row_e + 16'd1;
    assign reject    = (depth_e != BPP_SUPPORTED) || (width_e > cfg.max_width)
                     || (height_e > cfg.max_height);

    // Next state and result for one item
    always_comb
    begin
        phase_next      = ph_e;
        header_pos_next = pos_e;
        img_width_next  = width_e;
        img_height_next = height_e;
        bit_depth_next  = depth_e;
        data_left_next  = left_e;
        pad_bytes_next  = padb_e;
        pad_left_next   = padl_e;
        row_pixels_next = row_e;
        triple_pos_next = tri_e;
        blue_byte_next  = blue_byte_reg;
        green_byte_next = green_byte_reg;
        res_valid       = 1'b0;
        res             = '0;

        unique case (ph_e)
            PH_HEAD:
            begin
                case (pos_e)
                    HDR_WIDTH_LO:  img_width_next[7:0]   = byte_value;
                    HDR_WIDTH_HI:  img_width_next[15:8]  = byte_value;
                    HDR_HEIGHT_LO: img_height_next[7:0]  = byte_value;
                    HDR_HEIGHT_HI: img_height_next[15:8] = byte_value;
                    HDR_BPP:       bit_depth_next        = byte_value;
                    HDR_SIZE_B0:   data_left_next[7:0]   = byte_value;
                    HDR_SIZE_B1:   data_left_next[15:8]  = byte_value;
                    HDR_SIZE_B2:   data_left_next[23:16] = byte_value;
                    HDR_SIZE_B3:   data_left_next[31:24] = byte_value;
                    default:       ;
                endcase
                if (pos_e < HDR_LAST)
                begin
                    header_pos_next = pos_e + 6'd1;
                end
                else
                begin
                    // Last header byte: check the image and open the window
                    header_pos_next = 6'd0;
                    res_valid       = 1'b1;
                    if (reject)
                    begin
                        phase_next = PH_DONE;
                        res.kind   = KIND_REJECT;
                    end
                    else
                    begin
                        pad_bytes_next  = width_e[1:0];
                        pad_left_next   = 2'd0;
                        row_pixels_next = 16'd0;
                        triple_pos_next = 2'd0;
                        res.kind        = KIND_WINDOW;
                        res.win_left    = cfg.window_left;
                        res.win_top     = cfg.window_bottom - height_e + 16'd1;
                        res.win_right   = cfg.window_left + width_e - 16'd1;
                        res.win_low     = cfg.window_bottom;
                        res.image_done  = few_left;
                        phase_next      = few_left ? PH_DONE : PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                data_left_next = left_dec;
                if (padl_e != 2'd0)
                begin
                    // Skip row padding; the image may end on its last byte
                    pad_left_next = padl_dec;
                    if ((padl_dec == 2'd0) && few_after)
                    begin
                        phase_next     = PH_DONE;
                        res_valid      = 1'b1;
                        res.kind       = KIND_END;
                        res.image_done = 1'b1;
                    end
                end
                else if (tri_e == 2'd0)
                begin
                    blue_byte_next  = byte_value;
                    triple_pos_next = 2'd1;
                end
                else if (tri_e == 2'd1)
                begin
                    green_byte_next = byte_value;
                    triple_pos_next = 2'd2;
                end
                else
                begin
                    // Red byte completes a pixel
                    triple_pos_next = 2'd0;
                    res_valid       = 1'b1;
                    res.kind        = KIND_PIXEL;
                    res.color       = {byte_value[7:3], green_byte_reg[7:2],
                                       blue_byte_reg[7:3]};
                    if (few_after)
                    begin
                        phase_next     = PH_DONE;
                        res.image_done = 1'b1;
                    end
                    else if (row_inc == width_e)
                    begin
                        row_pixels_next = 16'd0;
                        pad_left_next   = padb_e;
                    end
                    else
                    begin
                        row_pixels_next = row_inc;
                    end
                end
            end
            default:
            begin
                // Idle or finished: stray bytes are dropped
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            header_pos_reg <= 6'd0;
            img_width_reg  <= 16'd0;
            img_height_reg <= 16'd0;
            bit_depth_reg  <= 8'd0;
            data_left_reg  <= 32'd0;
            pad_bytes_reg  <= 2'd0;
            pad_left_reg   <= 2'd0;
            row_pixels_reg <= 16'd0;
            triple_pos_reg <= 2'd0;
            blue_byte_reg  <= 8'd0;
            green_byte_reg <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            header_pos_reg <= header_pos_next;
            img_width_reg  <= img_width_next;
            img_height_reg <= img_height_next;
            bit_depth_reg  <= bit_depth_next;
            data_left_reg  <= data_left_next;
            pad_bytes_reg  <= pad_bytes_next;
            pad_left_reg   <= pad_left_next;
            row_pixels_reg <= row_pixels_next;
            triple_pos_reg <= triple_pos_next;
            blue_byte_reg  <= blue_byte_next;
            green_byte_reg <= green_byte_next;
        end
    end

    // The header counter never runs past the last header byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        header_pos_reg <= HDR_LAST)
        else $error("header position out of range");

    // A result that ends the image leaves the parser finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_valid && res.image_done) |=> (phase_reg == PH_DONE))
        else $error("image end without finishing");

    // Padding is only pending in the data phase or after the image has finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pad_left_reg != 2'd0) |-> (phase_reg == PH_DATA || phase_reg == PH_DONE))
        else $error("padding pending outside data phase");

endmodule

`default_nettype wire

// ===== src/bmp565_obuf.sv =====
// Result register with a skid entry, so input keeps flowing while a result waits.
// Depends on bmp565_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmp565_obuf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  bmp565_pkg::res_t       push_data,
    output logic                   can_take,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output bmp565_pkg::res_t       out_data
);
    import bmp565_pkg::*;

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_data_reg, out_data_next;
    res_t skid_data_reg, skid_data_next;
    logic pop;

    assign pop      = out_valid_reg && out_ready;
    assign can_take = !skid_valid_reg;

    // Refill the output register from the skid entry first
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_data_next = push_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The skid entry is only ever occupied behind a full output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds an item ahead of the output register");

    // The skid entry fills only when the output was held by the consumer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid entry filled without a stall");

endmodule

`default_nettype wire

// ===== src/bmp24_to_rgb565_stream.sv =====
// Top level of the streaming 24-bit BMP to RGB565 converter.
// Depends on bmp565_pkg, bmp565_cfg, bmp565_parse and bmp565_obuf.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one file byte per clock cycle while in_ready is high and gives
// its result, if any, through a registered output. Each byte is handled by
// a single pass through the parser's next-state logic, whose longest path is
// the 32-bit byte count decrement and its end test. Results go through an
// output register backed by one skid entry, so in_ready stays high while one
// result waits and drops only when both entries hold unread results. A byte
// marked start_of_file restarts parsing from header byte 0 at any time. The
// configuration registers take effect on the next header check and should
// only be written while the block has no results outstanding.
module bmp24_to_rgb565_stream (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  byte_value,
    input  wire logic        start_of_file,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [15:0]      win_left,
    output logic [15:0]      win_top,
    output logic [15:0]      win_right,
    output logic [15:0]      win_low,
    output logic [15:0]      color,
    output logic             image_done
);
    import bmp565_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t out_data;
    logic res_valid;
    logic fire;

    assign fire = in_valid && in_ready;

    bmp565_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bmp565_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .byte_value    (byte_value),
        .start_of_file (start_of_file),
        .cfg           (cfg),
        .res_valid     (res_valid),
        .res           (res)
    );

    bmp565_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire && res_valid),
        .push_data (res),
        .can_take  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Unpack the result onto the field ports
    assign kind       = out_data.kind;
    assign win_left   = out_data.win_left;
    assign win_top    = out_data.win_top;
    assign win_right  = out_data.win_right;
    assign win_low    = out_data.win_low;
    assign color      = out_data.color;
    assign image_done = out_data.image_done;

endmodule

`default_nettype wire

// ===== sim/bmp24_to_rgb565_stream_tb.sv =====
// Self-checking testbench for the streaming 24-bit BMP to RGB565 converter.
// It feeds BMP files byte by byte and checks each result against its own decoder.
// Depends on bmp565_pkg and bmp24_to_rgb565_stream.
`timescale 1ns / 1ps

module bmp24_to_rgb565_stream_tb;

    import bmp565_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_BYTES = 100;
    localparam int QUIET_BYTES  = 60;
    localparam int IDLE_TAIL    = 6;
    localparam int HDR_BYTES    = int'(HDR_LAST) + 1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_DATA,
        PH_FINISHED
    } parse_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_value = '0;
    logic        start_of_file = 1'b0;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [15:0] win_left;
    logic [15:0] win_top;
    logic [15:0] win_right;
    logic [15:0] win_low;
    logic [15:0] color;
    logic        image_done;

    // Decoder copy of the configuration and the parse state.
    logic [15:0]  max_w_reg;
    logic [15:0]  max_h_reg;
    logic [15:0]  left_reg;
    logic [15:0]  bottom_reg;
    parse_phase_t parse_phase;
    logic [5:0]   hdr_pos;
    logic [15:0]  img_w;
    logic [15:0]  img_h;
    logic [7:0]   bpp_field;
    logic [31:0]  bytes_left;
    logic [1:0]   row_pad;
    logic [1:0]   pad_todo;
    logic [15:0]  row_count;
    logic [1:0]   triple_pos;
    logic [7:0]   blue_hold;
    logic [7:0]   green_hold;

    // Results the decoder has produced and the block has not yet delivered.
    res_t rgb_results[$];

    int fail_count = 0;
    int bytes_sent = 0;
    int files_started = 0;
    int configs_loaded = 0;
    int n_window = 0;
    int n_pixel = 0;
    int n_end = 0;
    int n_reject = 0;
    int cycle_count = 0;
    int hold_cycles = 0;
    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;

    bmp24_to_rgb565_stream i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_value    (byte_value),
        .start_of_file (start_of_file),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .win_left      (win_left),
        .win_top       (win_top),
        .win_right     (win_right),
        .win_low       (win_low),
        .color         (color),
        .image_done    (image_done)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Put the decoder into its post-reset state.
    task automatic init_decoder();
        max_w_reg   = RST_MAX_WIDTH;
        max_h_reg   = RST_MAX_HEIGHT;
        left_reg    = RST_WINDOW_LEFT;
        bottom_reg  = RST_WINDOW_BOTTOM;
        parse_phase = PH_IDLE;
        hdr_pos     = '0;
        img_w       = '0;
        img_h       = '0;
        bpp_field   = '0;
        bytes_left  = '0;
        row_pad     = '0;
        pad_todo    = '0;
        row_count   = '0;
        triple_pos  = '0;
        blue_hold   = '0;
        green_hold  = '0;
    endtask

    // The byte count never goes below zero.
    task automatic consume_byte();
        if (bytes_left != 32'd0)
            bytes_left = bytes_left - 32'd1;
    endtask

    // Decode one accepted byte and queue the result it causes, if any.
    task automatic convert_byte(input logic [7:0] b, input logic sof);
        res_t r;
        logic emit;
        r = '0;
        emit = 1'b0;
        if (sof)
        begin
            hdr_pos     = '0;
            img_w       = '0;
            img_h       = '0;
            bpp_field   = '0;
            bytes_left  = '0;
            row_pad     = '0;
            pad_todo    = '0;
            row_count   = '0;
            triple_pos  = '0;
            parse_phase = PH_HEADER;
        end
        if (parse_phase == PH_HEADER)
        begin
            case (hdr_pos)
                HDR_WIDTH_LO:  img_w[7:0] = b;
                HDR_WIDTH_HI:  img_w[15:8] = b;
                HDR_HEIGHT_LO: img_h[7:0] = b;
                HDR_HEIGHT_HI: img_h[15:8] = b;
                HDR_BPP:       bpp_field = b;
                HDR_SIZE_B0:   bytes_left[7:0] = b;
                HDR_SIZE_B1:   bytes_left[15:8] = b;
                HDR_SIZE_B2:   bytes_left[23:16] = b;
                HDR_SIZE_B3:   bytes_left[31:24] = b;
                default: ;
            endcase
            if (hdr_pos != HDR_LAST)
                hdr_pos = hdr_pos + 6'd1;
            else
            begin
                // Header complete: either reject or open the display window.
                hdr_pos = '0;
                emit = 1'b1;
                if (bpp_field != BPP_SUPPORTED || img_w > max_w_reg || img_h > max_h_reg)
                begin
                    r.kind = KIND_REJECT;
                    parse_phase = PH_FINISHED;
                end
                else
                begin
                    row_pad    = img_w[1:0];
                    pad_todo   = '0;
                    row_count  = '0;
                    triple_pos = '0;
                    r.kind       = KIND_WINDOW;
                    r.win_left   = left_reg;
                    r.win_top    = bottom_reg - img_h + 16'd1;
                    r.win_right  = left_reg + img_w - 16'd1;
                    r.win_low    = bottom_reg;
                    r.image_done = (bytes_left < 32'd3);
                    parse_phase  = (bytes_left < 32'd3) ? PH_FINISHED : PH_DATA;
                end
            end
        end
        else if (parse_phase == PH_DATA)
        begin
            if (pad_todo != 2'd0)
            begin
                // Row padding; the image may end on its last byte.
                consume_byte();
                pad_todo = pad_todo - 2'd1;
                if (pad_todo == 2'd0 && bytes_left < 32'd3)
                begin
                    emit = 1'b1;
                    r.kind = KIND_END;
                    r.image_done = 1'b1;
                    parse_phase = PH_FINISHED;
                end
            end
            else if (triple_pos == 2'd0)
            begin
                blue_hold = b;
                triple_pos = 2'd1;
                consume_byte();
            end
            else if (triple_pos == 2'd1)
            begin
                green_hold = b;
                triple_pos = 2'd2;
                consume_byte();
            end
            else
            begin
                // Red byte completes the pixel.
                consume_byte();
                triple_pos = 2'd0;
                emit = 1'b1;
                r.kind = KIND_PIXEL;
                r.color = {b[7:3], green_hold[7:2], blue_hold[7:3]};
                if (bytes_left < 32'd3)
                begin
                    r.image_done = 1'b1;
                    parse_phase = PH_FINISHED;
                end
                else
                begin
                    row_count = row_count + 16'd1;
                    if (row_count == img_w)
                    begin
                        row_count = '0;
                        pad_todo = row_pad;
                    end
                end
            end
        end
        if (emit)
            rgb_results.push_back(r);
    endtask

    function automatic logic [31:0] image_bytes(input logic [15:0] w, input logic [15:0] h);
        return (32'(w) * 32'd3 + 32'(w[1:0])) * 32'(h);
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 3))
            0: return 16'd1;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 8));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    // Offer one byte, wait until it is taken, then update the decoder.
    // Returns at a falling edge with the valid still raised.
    task automatic send_byte(input logic [7:0] b, input logic sof);
        int gap;
        if (tx_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        byte_value    <= b;
        start_of_file <= sof;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        convert_byte(b, sof);
        bytes_sent++;
    endtask

    // Send the first hdr_len bytes of a header; unused bytes are random.
    task automatic send_header(input logic [15:0] w, input logic [15:0] h,
                               input logic [7:0] bpp, input logic [31:0] size,
                               input int hdr_len);
        logic [7:0] b;
        files_started++;
        for (int i = 0; i < hdr_len; i++)
        begin
            case (6'(i))
                HDR_WIDTH_LO:  b = w[7:0];
                HDR_WIDTH_HI:  b = w[15:8];
                HDR_HEIGHT_LO: b = h[7:0];
                HDR_HEIGHT_HI: b = h[15:8];
                HDR_BPP:       b = bpp;
                HDR_SIZE_B0:   b = size[7:0];
                HDR_SIZE_B1:   b = size[15:8];
                HDR_SIZE_B2:   b = size[23:16];
                HDR_SIZE_B3:   b = size[31:24];
                default:       b = 8'($urandom);
            endcase
            send_byte(b, i == 0);
        end
    endtask

    task automatic send_image(input logic [15:0] w, input logic [15:0] h,
                              input logic [7:0] bpp, input logic [31:0] size,
                              input int data_len);
        send_header(w, h, bpp, size, HDR_BYTES);
        repeat (data_len)
            send_byte(8'($urandom), 1'b0);
    endtask

    // Stop offering bytes and let every outstanding result drain.
    task automatic wait_idle();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (rgb_results.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (IDLE_TAIL) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_MAX_WIDTH:     max_w_reg = val;
            CFG_MAX_HEIGHT:    max_h_reg = val;
            CFG_WINDOW_LEFT:   left_reg = val;
            CFG_WINDOW_BOTTOM: bottom_reg = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic load_config(input logic [15:0] mw, input logic [15:0] mh,
                               input logic [15:0] wl, input logic [15:0] wb);
        wait_idle();
        write_reg(CFG_MAX_WIDTH, mw);
        write_reg(CFG_MAX_HEIGHT, mh);
        write_reg(CFG_WINDOW_LEFT, wl);
        write_reg(CFG_WINDOW_BOTTOM, wb);
        cfg_we <= 1'b0;
        configs_loaded++;
    endtask

    // Bytes sent before any start mark are ignored.
    task automatic test_stray_bytes();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b0);
    endtask

    // Two rows of two pixels under the reset window, with row padding.
    task automatic test_default_window();
        logic [7:0] pix [16] = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hA5, 8'h5A,
                                 8'h07, 8'h03, 8'h07, 8'h18, 8'hFC, 8'h80, 8'hC3, 8'h3C};
        send_header(16'd2, 16'd2, BPP_SUPPORTED, 32'd16, HDR_BYTES);
        foreach (pix[i])
            send_byte(pix[i], 1'b0);
    endtask

    // The image ends on the padding byte that follows its only pixel.
    task automatic test_end_after_padding();
        send_image(16'd1, 16'd1, BPP_SUPPORTED, 32'd6, 4);
    endtask

    // Fewer than three data bytes: the window result already ends the image.
    task automatic test_empty_data();
        send_image(16'd5, 16'd5, BPP_SUPPORTED, 32'd2, 2);
    endtask

    // An unsupported depth and an oversized image are refused.
    task automatic test_rejections();
        send_image(16'd2, 16'd2, 8'd32, 32'd16, 2);
        send_image(16'd1, 16'd241, BPP_SUPPORTED, 32'd3, 0);
    endtask

    // Zero width never completes a row and wraps the right edge; zero height puts the top row one past the bottom row.
    task automatic test_zero_size_image();
        send_image(16'd0, 16'd0, BPP_SUPPORTED, 32'd6, 6);
    endtask

    // A start mark restarts parsing in the middle of a header, and the next
    // file cuts this one off in the middle of its data.
    task automatic test_restart();
        send_header(16'd1, 16'd1, BPP_SUPPORTED, 32'hFFFF_FFFF, 10);
        send_image(16'd1, 16'd1, BPP_SUPPORTED, 32'hFFFF_FFFF, 8);
    endtask

    // The result side holds off long enough for the block to stall its input.
    // The image is left unfinished here and completed by the pause test.
    task automatic test_output_stall();
        wait_idle();
        tx_idle = 1'b0;
        hold_cycles = 90;
        send_header(16'd2, 16'd2, BPP_SUPPORTED, 32'd16, HDR_BYTES);
        repeat (10)
            send_byte(8'($urandom), 1'b0);
        tx_idle = 1'b1;
    endtask

    // The sender stops in the middle of an image until all results are in.
    task automatic test_sender_pause();
        wait_idle();
        repeat (6)
            send_byte(8'($urandom), 1'b0);
    endtask

    // Register extremes: largest limits and window, then the smallest.
    task automatic test_config_extremes();
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_image(16'hFFFF, 16'hFFFF, BPP_SUPPORTED, 32'd6, 6);
        load_config(16'd1, 16'd1, 16'd0, 16'd0);
        send_image(16'd2, 16'd1, BPP_SUPPORTED, 32'd8, 0);
    endtask

    // Mostly well-formed small images with random content, mixed with
    // broken headers, truncated or overlong data and stray bytes.
    task automatic test_random_files();
        int          first;
        int          n;
        bit          quiet;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  bpp;
        logic [31:0] size;
        first = bytes_sent;
        quiet = 1'b0;
        while (bytes_sent - first < RANDOM_BYTES)
        begin
            if (bytes_sent - first > RANDOM_BYTES - QUIET_BYTES)
                quiet = 1'b1;
            tx_idle = !quiet && ($urandom_range(0, 2) != 0);
            rx_idle = !quiet && ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 3) == 0)
                load_config(pick_limit(), pick_limit(), 16'($urandom), 16'($urandom));
            w = 16'($urandom_range(0, 5));
            h = 16'($urandom_range(0, 3));
            if (w > max_w_reg)
                w = max_w_reg;
            if (h > max_h_reg)
                h = max_h_reg;
            bpp = BPP_SUPPORTED;
            size = image_bytes(w, h);
            n = int'(size);
            case ($urandom_range(0, 9))
                0: bpp = 8'($urandom);
                1:
                begin
                    w = 16'($urandom);
                    h = 16'($urandom);
                    size = $urandom;
                    n = $urandom_range(0, 30);
                end
                2: n = $urandom_range(0, n);
                3:
                begin
                    size = size + $urandom_range(0, 5);
                    n = int'(size) + $urandom_range(0, 4);
                end
                4:
                begin
                    send_header(w, h, bpp, size, $urandom_range(1, HDR_BYTES - 1));
                    n = -1;
                end
                5:
                begin
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom), 1'b0);
                    n = -1;
                end
                default: ;
            endcase
            if (n >= 0)
                send_image(w, h, bpp, size, n);
        end
    endtask

    // Result side: random stall bursts, plus a long hold-off on request.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (rx_idle && $urandom_range(0, 6) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 9);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each delivered result with the oldest decoded one.
    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (rgb_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("Unexpected result: kind %0d color %h done %b",
                             kind, color, image_done);
            end
            else
            begin
                want = rgb_results.pop_front();
                case (want.kind)
                    KIND_WINDOW: n_window++;
                    KIND_PIXEL:  n_pixel++;
                    KIND_END:    n_end++;
                    KIND_REJECT: n_reject++;
                    default: ;
                endcase
                if (kind !== want.kind || win_left !== want.win_left ||
                    win_top !== want.win_top || win_right !== want.win_right ||
                    win_low !== want.win_low || color !== want.color ||
                    image_done !== want.image_done)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("Mismatch: kind exp %0d got %0d, color exp %h got %h,",
                                 want.kind, kind, want.color, color);
                        $display("  done exp %b got %b", want.image_done, image_done);
                        $display("  window l/t/r/b exp %h %h %h %h got %h %h %h %h",
                                 want.win_left, want.win_top, want.win_right, want.win_low,
                                 win_left, win_top, win_right, win_low);
                    end
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, rgb_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        init_decoder();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        test_stray_bytes();
        test_default_window();
        test_end_after_padding();
        test_empty_data();
        test_rejections();
        test_zero_size_image();
        test_restart();
        test_output_stall();
        test_sender_pause();
        test_config_extremes();
        test_random_files();

        wait_idle();
        if (rgb_results.size() != 0)
        begin
            $display("%0d results never arrived", rgb_results.size());
            fail_count += rgb_results.size();
        end

        $display("Sent %0d bytes in %0d files under %0d register loads.",
                 bytes_sent, files_started, configs_loaded);
        $display("Checked %0d windows, %0d pixels, %0d end marks and %0d rejections.",
                 n_window, n_pixel, n_end, n_reject);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
